/* design/assert_macros.svh */
// Assertion shorthands used by palette_hue_vote_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/phv_pkg.sv */
`default_nettype none

package phv_pkg;

  // Field widths fixed by the pixel, result and configuration formats.
  localparam int HUE_W      = 8;
  localparam int ENTRY_W    = 3;
  localparam int VOTES_W    = 20;
  localparam int PCOUNT_W   = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_HUES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_VALUE_MIN = 2'd3;

  // Reset values of the thresholds.
  localparam logic [HUE_W-1:0] THRESHOLD_RESET = 8'd15;
  localparam logic [HUE_W-1:0] VALUE_MIN_RESET = 8'd100;

  // Priority link handed from cell to cell: the first cell that reaches a new
  // maximum claims the lead, and later cells see it as taken.
  typedef struct packed {
    logic               taken;
    logic [ENTRY_W-1:0] idx;
  } link_t;

endpackage

`default_nettype wire

/* design/phv_cell.sv */
`default_nettype none

module phv_cell
  import phv_pkg::*;
#(
  parameter int COUNT_WIDTH = 20,
  parameter int ENTRY_INDEX = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   clear,
  input  wire logic                   pix_live,
  input  wire logic [HUE_W-1:0]       pix_hue,
  input  wire logic [HUE_W-1:0]       threshold,
  input  wire logic [HUE_W-1:0]       entry_hue,
  input  wire logic                   in_use,
  input  wire logic [COUNT_WIDTH-1:0] lead_votes,
  input  wire link_t                  link_in,
  output link_t                       link_out
);

  logic [COUNT_WIDTH-1:0] count;
  logic [HUE_W-1:0]       diff;
  logic                   match;
  logic                   saturated;
  logic                   hit;

  // Hue distance without wrap, and the vote decision for this entry.
  assign diff      = (entry_hue > pix_hue) ? (entry_hue - pix_hue) : (pix_hue - entry_hue);
  assign match     = pix_live && in_use && (diff <= threshold);
  assign saturated = (count == {COUNT_WIDTH{1'b1}});

  // A vote lifts this entry past the current maximum only from equal footing.
  assign hit = match && !saturated && (count == lead_votes);

  // Pass the lead claim on: the lowest hitting index keeps it.
  always_comb begin
    link_out.taken = link_in.taken || hit;
    link_out.idx   = link_in.taken ? link_in.idx : ENTRY_W'(ENTRY_INDEX);
  end

  // Saturating vote counter, cleared after the last pixel of a region.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      if (clear) begin
        count <= '0;
      end else if (match && !saturated) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/palette_hue_vote_core.sv */
// A region's last pixel is taken into the pixel register stage; its result is then loaded into the result register.
// Throughput: one pixel per cycle; all palette cells vote in the same cycle.
// Only a last pixel waits, and only while the previous result is still not taken.
// Reset (synchronous, active high) clears all vote counts and the leader, and
// sets the configuration to its defaults (threshold 15, white value minimum 100).
`default_nettype none

module palette_hue_vote_core
  import phv_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 8,
  parameter int COUNT_WIDTH     = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Pixel channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [HUE_W-1:0]      hue,
  input  wire logic [HUE_W-1:0]      saturation,
  input  wire logic [HUE_W-1:0]      brightness,
  input  wire logic                  region_end,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       found,
  output logic [ENTRY_W-1:0]         best_entry,
  output logic [VOTES_W-1:0]         best_votes
);

  `include "assert_macros.svh"

  localparam int HUES_W = PALETTE_ENTRIES * HUE_W;

  // Configuration registers.
  logic [HUES_W-1:0]   palette_hues;
  logic [PCOUNT_W-1:0] palette_count;
  logic [HUE_W-1:0]    match_threshold;
  logic [HUE_W-1:0]    white_value_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_hues    <= '0;
      palette_count   <= '0;
      match_threshold <= THRESHOLD_RESET;
      white_value_min <= VALUE_MIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PALETTE_HUES:    palette_hues    <= cfg_data[HUES_W-1:0];
        REG_PALETTE_COUNT:   palette_count   <= cfg_data[PCOUNT_W-1:0];
        REG_MATCH_THRESHOLD: match_threshold <= cfg_data[HUE_W-1:0];
        REG_WHITE_VALUE_MIN: white_value_min <= cfg_data[HUE_W-1:0];
      endcase
    end
  end

  // Pixel register stage: the white test is done on the way in.
  logic             s1_valid;
  logic             s1_last;
  logic             s1_live;
  logic [HUE_W-1:0] s1_hue;
  logic             out_free;
  logic             step;
  logic             in_xfer;
  logic             is_white;

  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || step;
  assign in_xfer  = in_valid && in_ready;
  assign is_white = (hue <= match_threshold) && (saturation <= match_threshold) &&
                    (brightness >= white_value_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_hue  <= hue;
      s1_live <= !is_white;
      s1_last <= region_end;
    end
  end

  // Leader state: lead_votes always equals the largest vote count.
  logic [COUNT_WIDTH-1:0] lead_votes;
  logic [ENTRY_W-1:0]     lead_idx;
  logic                   lead_valid;
  logic [COUNT_WIDTH-1:0] lead_votes_next;
  logic [ENTRY_W-1:0]     lead_idx_next;
  logic                   lead_valid_next;

  // Row of voting cells linked by the lead claim.
  link_t links [PALETTE_ENTRIES+1];

  assign links[0] = '{taken: 1'b0, idx: '0};

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    logic in_use;
    assign in_use = (palette_count > PCOUNT_W'(i));

    phv_cell #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .ENTRY_INDEX(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .clear     (s1_last),
      .pix_live  (s1_live),
      .pix_hue   (s1_hue),
      .threshold (match_threshold),
      .entry_hue (palette_hues[i*HUE_W +: HUE_W]),
      .in_use    (in_use),
      .lead_votes(lead_votes),
      .link_in   (links[i]),
      .link_out  (links[i+1])
    );
  end

  // A claim at the end of the row raises the maximum by one.
  always_comb begin
    lead_votes_next = lead_votes;
    lead_idx_next   = lead_idx;
    lead_valid_next = lead_valid;
    if (links[PALETTE_ENTRIES].taken) begin
      lead_votes_next = lead_votes + 1'b1;
      lead_idx_next   = links[PALETTE_ENTRIES].idx;
      lead_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_votes <= '0;
      lead_idx   <= '0;
      lead_valid <= 1'b0;
    end else if (step) begin
      if (s1_last) begin
        lead_votes <= '0;
        lead_idx   <= '0;
        lead_valid <= 1'b0;
      end else begin
        lead_votes <= lead_votes_next;
        lead_idx   <= lead_idx_next;
        lead_valid <= lead_valid_next;
      end
    end
  end

  // Vote count on the output saturates at the port width.
  logic [VOTES_W-1:0] votes_out;

  if (COUNT_WIDTH > VOTES_W) begin : g_votes_clip
    assign votes_out = (|lead_votes_next[COUNT_WIDTH-1:VOTES_W]) ?
                       {VOTES_W{1'b1}} : lead_votes_next[VOTES_W-1:0];
  end else begin : g_votes_ext
    assign votes_out = VOTES_W'(lead_votes_next);
  end

  // Result register; a waiting result does not hold up ordinary pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      found      <= lead_valid_next;
      best_entry <= lead_idx_next;
      best_votes <= votes_out;
    end
  end

  // Consistency checks.
  `ASSERT_IMPLY(a_no_leader_no_votes, clk, rst, !lead_valid, lead_votes == '0)
  `ASSERT_IMPLY(a_stall_only_on_last, clk, rst, !in_ready, s1_valid && s1_last)
  `ASSERT_NEXT(a_region_end_clears, clk, rst, step && s1_last, !lead_valid)
  `ASSERT_NEXT(a_region_end_result, clk, rst, step && s1_last, out_valid)

endmodule

`default_nettype wire
